// File: sv/pcp_pkg.sv
`timescale 1ns / 1ps
// pcp_pkg: shared types, codes and constants of the PWM command text parser.
// No dependencies; every other file of the block imports it.
package pcp_pkg;

	localparam int VALUE_BITS = 14;
	localparam int WIDE_BITS  = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

	// register file: three registers at byte addresses 0, 4, 8
	localparam int CFG_COUNT = 3;
	localparam int IDX_BITS  = $clog2(CFG_COUNT);
	localparam int ADDR_BITS = IDX_BITS + 2;
	localparam int DATA_BITS = 32;

	localparam logic [VALUE_BITS-1:0] FREQ_MIN_RST = VALUE_BITS'(15);
	localparam logic [VALUE_BITS-1:0] FREQ_MAX_RST = VALUE_BITS'(10000);
	localparam logic [VALUE_BITS-1:0] DUTY_MAX_RST = VALUE_BITS'(100);

	localparam logic [7:0] CHR_F    = 8'h46;
	localparam logic [7:0] CHR_D    = 8'h44;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_NINE = 8'h39;

	typedef enum logic [1:0] {
		CMD_UNKNOWN = 2'd0,
		CMD_FREQ    = 2'd1,
		CMD_DUTY    = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NONDIGIT = 3'd1,
		ST_LEADZERO = 3'd2,
		ST_TOOLARGE = 3'd3,
		ST_TOOSMALL = 3'd4,
		ST_UNKNOWN  = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_t;

	typedef struct packed {
		cmd_t                  command;
		logic [VALUE_BITS-1:0] value;
		status_t               status;
	} out_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] freq_min;
		logic [VALUE_BITS-1:0] freq_max;
		logic [VALUE_BITS-1:0] duty_max;
	} cfg_t;

endpackage

// File: sv/pcp_regs.sv
`timescale 1ns / 1ps
// pcp_regs: APB-style configuration registers (freq_min, freq_max, duty_max).
// Depends on pcp_pkg.
module pcp_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pcp_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [pcp_pkg::DATA_BITS-1:0]  pwdata,
	output logic [pcp_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output pcp_pkg::cfg_t                  cfg
);
	import pcp_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_FREQ_MIN = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_FREQ_MAX = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_DUTY_MAX = IDX_BITS'(2);

	logic [VALUE_BITS-1:0] freq_min_q;
	logic [VALUE_BITS-1:0] freq_max_q;
	logic [VALUE_BITS-1:0] duty_max_q;
	logic [IDX_BITS-1:0]   idx;
	logic                  wr_en;

	assign idx    = paddr[ADDR_BITS-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_min_q <= FREQ_MIN_RST;
			freq_max_q <= FREQ_MAX_RST;
			duty_max_q <= DUTY_MAX_RST;
		end else if (wr_en) begin
			case (idx)
				REG_FREQ_MIN: freq_min_q <= pwdata[VALUE_BITS-1:0];
				REG_FREQ_MAX: freq_max_q <= pwdata[VALUE_BITS-1:0];
				REG_DUTY_MAX: duty_max_q <= pwdata[VALUE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FREQ_MIN: prdata = DATA_BITS'(freq_min_q);
			REG_FREQ_MAX: prdata = DATA_BITS'(freq_max_q);
			REG_DUTY_MAX: prdata = DATA_BITS'(duty_max_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg = '{freq_min: freq_min_q, freq_max: freq_max_q, duty_max: duty_max_q};

endmodule

// File: sv/pcp_core.sv
`timescale 1ns / 1ps
// pcp_core: packet state and the per-character parse step (one char per cycle while step is high).
// Depends on pcp_pkg.
module pcp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  pcp_pkg::in_t   chr,
	input  pcp_pkg::cfg_t  cfg,
	output pcp_pkg::out_t  res
);
	import pcp_pkg::*;

	logic                  in_packet_q, in_packet_d;
	cmd_t                  cmd_q, cmd_d;
	logic [VALUE_BITS-1:0] accum_q, accum_d;
	status_t               err_q, err_d;
	logic                  first_q, first_d;
	logic                  ovf_q, ovf_d;

	logic                  is_digit;
	logic [WIDE_BITS-1:0]  prod;
	status_t               status;

	assign is_digit = chr.char_code inside {[CHR_ZERO:CHR_NINE]};
	// accum * 10 + digit; '0'..'9' carry the digit in the low nibble
	assign prod = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
		+ WIDE_BITS'(chr.char_code[3:0]);

	always_comb begin
		in_packet_d = in_packet_q;
		cmd_d       = cmd_q;
		accum_d     = accum_q;
		err_d       = err_q;
		first_d     = first_q;
		ovf_d       = ovf_q;

		if (!in_packet_q) begin
			in_packet_d = 1'b1;
			accum_d     = '0;
			ovf_d       = 1'b0;
			first_d     = 1'b1;
			err_d       = ST_OK;
			if (chr.char_code == CHR_F) begin
				cmd_d = CMD_FREQ;
			end else if (chr.char_code == CHR_D) begin
				cmd_d = CMD_DUTY;
			end else begin
				cmd_d = CMD_UNKNOWN;
				err_d = ST_UNKNOWN;
			end
		end else if (err_q == ST_OK) begin
			if (!is_digit) begin
				err_d = ST_NONDIGIT;
			end else if (first_q && cmd_q == CMD_FREQ && chr.char_code == CHR_ZERO) begin
				err_d   = ST_LEADZERO;
				first_d = 1'b0;
			end else begin
				first_d = 1'b0;
				if (prod > WIDE_BITS'(VALUE_MAX)) begin
					accum_d = VALUE_MAX;
					ovf_d   = 1'b1;
				end else begin
					accum_d = prod[VALUE_BITS-1:0];
				end
			end
		end

		// end-of-packet range checks, only when no character error
		status = err_d;
		if (err_d == ST_OK) begin
			if (cmd_d == CMD_FREQ) begin
				if (ovf_d || accum_d > cfg.freq_max) begin
					status = ST_TOOLARGE;
				end else if (accum_d < cfg.freq_min) begin
					status = ST_TOOSMALL;
				end
			end else if (ovf_d || accum_d > cfg.duty_max) begin
				status = ST_TOOLARGE;
			end
		end

		res.command = cmd_d;
		res.status  = status;
		res.value   = (status == ST_OK || status == ST_TOOLARGE || status == ST_TOOSMALL)
			? accum_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			cmd_q       <= CMD_UNKNOWN;
			accum_q     <= '0;
			err_q       <= ST_OK;
			first_q     <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (step) begin
			if (chr.last_char) begin
				in_packet_q <= 1'b0;
				cmd_q       <= CMD_UNKNOWN;
				accum_q     <= '0;
				err_q       <= ST_OK;
				first_q     <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				in_packet_q <= in_packet_d;
				cmd_q       <= cmd_d;
				accum_q     <= accum_d;
				err_q       <= err_d;
				first_q     <= first_d;
				ovf_q       <= ovf_d;
			end
		end
	end

endmodule

// File: sv/pwm_command_text_parser.sv
`timescale 1ns / 1ps
// pwm_command_text_parser: top level; input register, parse core, result register.
// Depends on pcp_pkg, pcp_regs, pcp_core.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  in        | in_valid / in_ready        | in_data  (char_code, last_char)
//  out       | out_valid / out_ready      | out_data (command, value, status)
//  config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One character per cycle sustained unless a last character waits on a full result
// register. A request sits in the input register and the parse step runs between it
// and the result register, so out_valid rises once the last character is stepped.
// Reset (arst_n low) clears the packet state, both valid flags and restores
// freq_min=15, freq_max=10000, duty_max=100.
// A stalled result holds only characters marked last; other characters keep
// flowing into the packet state while out_ready is low.
module pwm_command_text_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pcp_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pcp_pkg::out_t                  out_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pcp_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [pcp_pkg::DATA_BITS-1:0]  pwdata,
	output logic [pcp_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready
);
	import pcp_pkg::*;

	cfg_t cfg;
	in_t  chr_s1;
	logic valid_s1;
	out_t res;
	out_t res_s2;
	logic valid_s2;
	logic step;

	pcp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the char in stage 1 is consumed unless it ends a packet and the
	// result register is still occupied
	assign step     = valid_s1 && (!chr_s1.last_char || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step;

	pcp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.chr    (chr_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			chr_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && chr_s1.last_char) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && chr_s1.last_char) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// File: sv/pcp_checker.sv
`timescale 1ns / 1ps
// pcp_checker: port-level checks on the result channel, bound to the top level.
// Depends on pcp_pkg and pwm_command_text_parser.
module pcp_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          out_valid,
	input  logic          out_ready,
	input  pcp_pkg::out_t out_data
);
	import pcp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_NONDIGIT || out_data.status == ST_LEADZERO
			|| out_data.status == ST_UNKNOWN) |-> out_data.value == '0)
		else $error("nonzero value with character error");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.command == CMD_UNKNOWN) == (out_data.status == ST_UNKNOWN)))
		else $error("unknown command and status disagree");

	a_freq_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_TOOSMALL || out_data.status == ST_LEADZERO)
		|-> out_data.command == CMD_FREQ)
		else $error("frequency-only status on other command");

endmodule

bind pwm_command_text_parser pcp_checker u_pcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: bench/pwm_command_text_parser_test.sv
`timescale 1ns / 1ps
// pwm_command_text_parser_test: self-checking bench for the PWM command text parser.
// Depends on pcp_pkg and pwm_command_text_parser; drives a directed table and random traffic, checks every reply.
module pwm_command_text_parser_test;
	import pcp_pkg::*;

	// register indexes, byte address is 4 * index
	localparam int REG_FREQ_MIN = 0;
	localparam int REG_FREQ_MAX = 1;
	localparam int REG_DUTY_MAX = 2;

	localparam int MAX_WAIT     = 13;      // longest idle draw on either side
	localparam int HOLD_CYCLES  = 400;     // long receiver stall, fills the block
	localparam int DRAIN_CYCLES = 6;       // block latency plus margin
	localparam int CYCLE_LIMIT  = 400000;  // slowest correct run is far below this
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 255;

	// one row of the directed table; res is only meaningful when typed is set
	typedef struct packed {
		logic [7:0] chr;
		logic       last;
		logic       typed;
		out_t       res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	pwm_command_text_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// expected replies, oldest first
	out_t replies_due[$];
	dir_row_t dir_tab[$];
	int fail_count = 0;
	int cycle_count = 0;
	int chars_sent = 0;
	bit steady = 0;        // when set, neither side inserts idle cycles
	bit hold_off_req = 0;  // asks the receiver for one long stall

	// parser shadow: packet state and register copy
	bit                    pk_open;
	cmd_t                  pk_cmd;
	logic [VALUE_BITS-1:0] pk_acc;
	status_t               pk_err;
	bit                    pk_first;
	bit                    pk_sat;
	logic [VALUE_BITS-1:0] cfg_fmin;
	logic [VALUE_BITS-1:0] cfg_fmax;
	logic [VALUE_BITS-1:0] cfg_dmax;

	out_t want;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pwm_command_text_parser_test failed");
			$finish;
		end
	end

	// Advance the shadow parser by one character. Returns 1 when the character
	// closes a packet, with the reply it must produce in res.
	function automatic bit parse_char(input in_t d, output out_t res);
		logic [VALUE_BITS+3:0] nxt;
		status_t st;
		res = '0;
		if (!pk_open) begin
			// letter: pick the command, start a fresh packet
			pk_open  = 1;
			pk_acc   = '0;
			pk_sat   = 0;
			pk_first = 1;
			pk_err   = ST_OK;
			if (d.char_code == CHR_F) begin
				pk_cmd = CMD_FREQ;
			end else if (d.char_code == CHR_D) begin
				pk_cmd = CMD_DUTY;
			end else begin
				pk_cmd = CMD_UNKNOWN;
				pk_err = ST_UNKNOWN;
			end
		end else if (pk_err == ST_OK) begin
			// digits only count until the first error
			if (d.char_code < CHR_ZERO || d.char_code > CHR_NINE) begin
				pk_err = ST_NONDIGIT;
			end else if (pk_first && pk_cmd == CMD_FREQ && d.char_code == CHR_ZERO) begin
				pk_err   = ST_LEADZERO;
				pk_first = 0;
			end else begin
				pk_first = 0;
				nxt = pk_acc * 10 + (d.char_code - CHR_ZERO);
				if (nxt > VALUE_MAX) begin
					nxt    = VALUE_MAX;
					pk_sat = 1;
				end
				pk_acc = nxt[VALUE_BITS-1:0];
			end
		end
		if (!d.last_char)
			return 0;
		// range checks only when no character error was seen
		st = pk_err;
		if (st == ST_OK) begin
			if (pk_cmd == CMD_FREQ) begin
				if (pk_sat || pk_acc > cfg_fmax)
					st = ST_TOOLARGE;
				else if (pk_acc < cfg_fmin)
					st = ST_TOOSMALL;
			end else if (pk_sat || pk_acc > cfg_dmax) begin
				st = ST_TOOLARGE;
			end
		end
		res.command = pk_cmd;
		res.value   = (st == ST_OK || st == ST_TOOLARGE || st == ST_TOOSMALL) ? pk_acc : '0;
		res.status  = st;
		pk_open = 0;
		return 1;
	endfunction

	function automatic dir_row_t tab_char(input logic [7:0] c, input logic last);
		tab_char = '{chr: c, last: last, typed: 1'b0, res: '0};
	endfunction

	// closing character whose reply is obvious enough to spell out
	function automatic dir_row_t tab_end(input logic [7:0] c, input cmd_t cmd,
			input int val, input status_t st);
		out_t r;
		r.command = cmd;
		r.value   = VALUE_BITS'(val);
		r.status  = st;
		tab_end = '{chr: c, last: 1'b1, typed: 1'b1, res: r};
	endfunction

	// Offer one request after a random gap, hold it until taken, then log
	// the reply it owes. Leaves in_valid high so back-to-back requests stay clean.
	task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
			input out_t typed_res);
		int gap;
		in_t d;
		out_t res;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		d.char_code = c;
		d.last_char = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (!in_ready);
		chars_sent++;
		if (parse_char(d, res))
			replies_due.push_back(typed ? typed_res : res);
	endtask

	// One random packet: mostly well-formed F/D commands with random digits,
	// some unknown letters and stray bytes.
	task automatic send_packet();
		int pick;
		int n;
		int bad_at;
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0)
			steady = !steady;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			c = CHR_F;
		else if (pick < 85)
			c = CHR_D;
		else
			c = 8'($urandom_range(0, 255));
		// short values mostly, a few long enough to saturate
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
		bad_at = (n > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n) : -1;
		send_char(c, n == 0, 0, '0);
		for (int i = 1; i <= n; i++) begin
			if (i == bad_at)
				c = 8'($urandom_range(0, 255));
			else
				c = CHR_ZERO + 8'($urandom_range(0, 9));
			send_char(c, i == n, 0, '0);
		end
	endtask

	// APB write then read back; junk in the upper data bits must be dropped
	task automatic write_reg(input int idx, input logic [VALUE_BITS-1:0] val);
		logic [DATA_BITS-1:0] word;
		word = $urandom;
		word[VALUE_BITS-1:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'(idx * 4);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[VALUE_BITS-1:0] !== val) begin
			$display("%0t: register %0d read expected %0d got %0d", $time, idx, val,
				prdata[VALUE_BITS-1:0]);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_FREQ_MIN: cfg_fmin = val;
			REG_FREQ_MAX: cfg_fmax = val;
			REG_DUTY_MAX: cfg_dmax = val;
			default: ;
		endcase
		// bus idle before the next transfer
		@(posedge clk);
	endtask

	// drop valid, let every owed reply come back, then let the pipe settle
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Receiver: random stall before each reply, one long hold-off on request.
	initial begin
		int stall;
		out_ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 0;
			end
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && !hold_off_req);
		end
	end

	// Reply checker: every taken reply against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply cmd %0d value %0d status %0d", $time,
					out_data.command, out_data.value, out_data.status);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (out_data.command !== want.command) begin
					$display("%0t: command expected %0d got %0d", $time, want.command,
						out_data.command);
					fail_count++;
				end
				if (out_data.value !== want.value) begin
					$display("%0t: value expected %0d got %0d", $time, want.value,
						out_data.value);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						out_data.status);
					fail_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases with new settings.
	initial begin
		logic [VALUE_BITS-1:0] plan [3];
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		pk_open  = 0;
		pk_cmd   = CMD_UNKNOWN;
		pk_acc   = '0;
		pk_err   = ST_OK;
		pk_first = 0;
		pk_sat   = 0;
		cfg_fmin = FREQ_MIN_RST;
		cfg_fmax = FREQ_MAX_RST;
		cfg_dmax = DUTY_MAX_RST;

		// directed cases, run against the reset register values
		dir_tab.push_back(tab_end(CHR_F, CMD_FREQ, 0, ST_TOOSMALL));     // empty F
		dir_tab.push_back(tab_end(CHR_D, CMD_DUTY, 0, ST_OK));           // empty D
		dir_tab.push_back(tab_char(CHR_F, 0));                           // leading zero
		dir_tab.push_back(tab_char("0", 0));                             // wins over the
		dir_tab.push_back(tab_end("A", CMD_FREQ, 0, ST_LEADZERO));       // later non-digit
		dir_tab.push_back(tab_char(CHR_D, 0));                           // D takes zeros
		dir_tab.push_back(tab_char("0", 0));
		dir_tab.push_back(tab_char("7", 1));
		dir_tab.push_back(tab_char(CHR_F, 0));                           // just past '9'
		dir_tab.push_back(tab_end(":", CMD_FREQ, 0, ST_NONDIGIT));
		dir_tab.push_back(tab_char(8'h00, 0));                           // unknown letter,
		dir_tab.push_back(tab_end(8'hFF, CMD_UNKNOWN, 0, ST_UNKNOWN));   // tail unchecked
		dir_tab.push_back(tab_char(CHR_F, 0));                           // saturates
		for (int i = 0; i < 4; i++)
			dir_tab.push_back(tab_char("9", 0));
		dir_tab.push_back(tab_end("9", CMD_FREQ, 16383, ST_TOOLARGE));
		dir_tab.push_back(tab_char(CHR_D, 0));                           // duty over max
		dir_tab.push_back(tab_char("1", 0));
		dir_tab.push_back(tab_char("0", 0));
		dir_tab.push_back(tab_end("1", CMD_DUTY, 101, ST_TOOLARGE));
		dir_tab.push_back(tab_char(CHR_F, 0));                           // below freq_min
		dir_tab.push_back(tab_char("1", 0));
		dir_tab.push_back(tab_end("4", CMD_FREQ, 14, ST_TOOSMALL));
		dir_tab.push_back(tab_char(CHR_D, 0));                           // just below '0'
		dir_tab.push_back(tab_end("/", CMD_DUTY, 0, ST_NONDIGIT));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_char(dir_tab[i].chr, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain(DRAIN_CYCLES);
				case (ph)
					1: plan = '{'0, VALUE_MAX, VALUE_MAX};   // widest ranges
					2: plan = '{VALUE_MAX, '0, '0};          // nothing fits
					3: plan = '{VALUE_BITS'(1), VALUE_BITS'(999), VALUE_BITS'(50)};
					4: plan = '{VALUE_BITS'($urandom_range(0, 200)),
						VALUE_BITS'($urandom_range(0, VALUE_MAX)),
						VALUE_BITS'($urandom_range(0, 999))};
					default: plan = '{FREQ_MIN_RST, FREQ_MAX_RST, DUTY_MAX_RST};
				endcase
				write_reg(REG_FREQ_MIN, plan[0]);
				write_reg(REG_FREQ_MAX, plan[1]);
				write_reg(REG_DUTY_MAX, plan[2]);
			end
			// first random stretch: receiver freezes while requests keep coming
			if (ph == 0)
				hold_off_req = 1;
			while (chars_sent < dir_tab.size() + (ph + 1) * PHASE_ITEMS)
				send_packet();
		end

		drain(DRAIN_CYCLES);
		if (fail_count == 0 && replies_due.size() == 0) begin
			$display("pwm_command_text_parser_test passed");
		end else begin
			$display("pwm_command_text_parser_test failed");
		end
		$finish;
	end

endmodule
